[rtl/core/weighted_mean_table_accumulator_unit_defines.svh]
// ----------------------------------------------------------------------------
// weighted mean table accumulator - assertion macros
// concurrent check helpers clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MEAN_TABLE_ACCUMULATOR_UNIT_DEFINES_SVH
`define WEIGHTED_MEAN_TABLE_ACCUMULATOR_UNIT_DEFINES_SVH

// property must hold at every edge out of reset
`define WMTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define WMTA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/core/wmta_pkg.sv]
// ----------------------------------------------------------------------------
// wmta_pkg
// shared types and constants of the weighted mean table accumulator
// ----------------------------------------------------------------------------
package wmta_pkg;

  localparam int unsigned SUM_W      = 56;
  localparam int unsigned TOTAL_W    = 40;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned COUNT_W    = 20;
  localparam int unsigned PROD_W     = VALUE_W + COUNT_W;
  localparam int unsigned QUOT_W     = 17;
  localparam int unsigned IDX_CALC_W = 18;
  localparam int unsigned LAGS_W     = 7;
  localparam int unsigned DIAS_W     = 4;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [VALUE_W-1:0] ONE_Q15    = 16'h8000;
  localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [LAGS_W-1:0]  LAGS_RESET = 7'd64;
  localparam logic [DIAS_W-1:0]  DIAS_RESET = 4'd8;

  // register select, taken from paddr[2]
  localparam logic CFG_LAGS = 1'b0;
  localparam logic CFG_DIAS = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_FINAL = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         lag_num;
    logic [2:0]         diameter_index;
    logic [3:0]         point_index;
    logic [VALUE_W-1:0] survival_value;
    logic [COUNT_W-1:0] chain_count;
    logic               add_count;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mean_value;
    logic               empty_lag;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic             mark;
    logic [SUM_W-1:0] sum;
  } sum_entry_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [TOTAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/weighted_mean_table_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// weighted_mean_table_accumulator_unit
// count-weighted ensemble average table: weighted sums per entry, weight
// totals per lag, clear / accumulate / finalize commands
// ----------------------------------------------------------------------------
//
//  channel   signals                               handshake
//  -------   -----------------------------------   ------------------------------
//  command   start, busy, item_i                   taken when start && !busy
//  result    done_o, result_o                      one-cycle strobe, no backpressure
//  config    psel penable pwrite paddr pwdata      write on psel&penable&pwrite
//            prdata pready                         pready tied high
//
//  sequence: accumulate steps through index, read and modify-write before
//  the next command is accepted; finalize of a non-empty lag waits on the
//  one-bit-a-cycle divider (17 steps); an out-of-range command returns to idle after index.
//  clear sweeps the table memory one entry a cycle over all TABLE_DEPTH
//  entries (8192 at default parameters), after reset and for every clear command.
//  busy is high during the sweep and while a command is in work; results
//  are registered outputs and cannot be stalled.
// ----------------------------------------------------------------------------
`include "weighted_mean_table_accumulator_unit_defines.svh"

module weighted_mean_table_accumulator_unit
  import wmta_pkg::*;
#(
  parameter int unsigned POINTS_PER_LAG = 16,
  parameter int unsigned MAX_LAGS       = 64,
  parameter int unsigned MAX_DIAMETERS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // command words
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item_i,
  // result words
  output logic                  done_o,
  output result_t               result_o
);

  localparam int unsigned TABLE_DEPTH = MAX_DIAMETERS * MAX_LAGS * POINTS_PER_LAG;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_INDEX  = 3'd2;
  localparam logic [2:0] ST_MODIFY = 3'd3;
  localparam logic [2:0] ST_DIVIDE = 3'd4;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [LAGS_W-1:0] lags_cfg_q;
  logic [DIAS_W-1:0] dias_cfg_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lags_cfg_q <= LAGS_RESET;
      dias_cfg_q <= DIAS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_LAGS: lags_cfg_q <= pwdata[LAGS_W-1:0];
        CFG_DIAS: dias_cfg_q <= pwdata[DIAS_W-1:0];
        default:  lags_cfg_q <= lags_cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_LAGS: prdata = APB_DATA_W'(lags_cfg_q);
      CFG_DIAS: prdata = APB_DATA_W'(dias_cfg_q);
      default:  prdata = '0;
    endcase
  end

  // effective counts, clamped to 1..max
  logic [LAGS_W-1:0] lags_eff;
  logic [DIAS_W-1:0] dias_eff;

  always_comb begin
    if (lags_cfg_q == '0) begin
      lags_eff = LAGS_W'(1);
    end else if (32'(lags_cfg_q) > MAX_LAGS) begin
      lags_eff = LAGS_W'(MAX_LAGS);
    end else begin
      lags_eff = lags_cfg_q;
    end
    if (dias_cfg_q == '0) begin
      dias_eff = DIAS_W'(1);
    end else if (32'(dias_cfg_q) > MAX_DIAMETERS) begin
      dias_eff = DIAS_W'(MAX_DIAMETERS);
    end else begin
      dias_eff = dias_cfg_q;
    end
  end

  // --------------------------------------------------------------------------
  // state and payload registers
  // --------------------------------------------------------------------------
  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic               done_q, done_d;
  item_t              item_q, item_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  result_t            result_q, result_d;

  // --------------------------------------------------------------------------
  // table memory (sum plus saturation mark) and lag total memory
  // --------------------------------------------------------------------------
  sum_entry_t         sum_mem [TABLE_DEPTH];
  logic [TOTAL_W-1:0] lag_mem [MAX_LAGS];

  logic               rd_en;
  logic [AW-1:0]      sum_raddr;
  logic [LW-1:0]      lag_raddr;
  sum_entry_t         sum_rd_q;
  logic [TOTAL_W-1:0] lag_rd_q;

  logic               sum_we;
  logic [AW-1:0]      sum_waddr;
  sum_entry_t         sum_wdata;
  logic               lag_we;
  logic [LW-1:0]      lag_waddr;
  logic [TOTAL_W-1:0] lag_wdata;

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    if (rd_en) begin
      sum_rd_q <= sum_mem[sum_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lag_we) begin
      lag_mem[lag_waddr] <= lag_wdata;
    end
    if (rd_en) begin
      lag_rd_q <= lag_mem[lag_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // index arithmetic: (diameter*lags + lag)*points + point
  // --------------------------------------------------------------------------
  logic [IDX_CALC_W-1:0] idx_wide;
  logic                  in_range;
  logic [VALUE_W-1:0]    value_clamped;

  assign idx_wide = (IDX_CALC_W'(item_q.diameter_index) * IDX_CALC_W'(lags_eff)
                     + IDX_CALC_W'(item_q.lag_num)) * IDX_CALC_W'(POINTS_PER_LAG)
                    + IDX_CALC_W'(item_q.point_index);

  assign in_range = ({1'b0, item_q.lag_num} < lags_eff)
                 && ({1'b0, item_q.diameter_index} < dias_eff)
                 && (32'(item_q.point_index) < POINTS_PER_LAG)
                 && (32'(idx_wide) < TABLE_DEPTH);

  // survival above one counts as one
  assign value_clamped = (item_q.survival_value > ONE_Q15) ? ONE_Q15
                                                           : item_q.survival_value;

  // --------------------------------------------------------------------------
  // modify arithmetic: saturating adds, carry out flags overflow
  // --------------------------------------------------------------------------
  logic [SUM_W:0]     sum_add;
  logic [TOTAL_W:0]   total_add;
  logic               sat_flag;

  assign sum_add   = {1'b0, sum_rd_q.sum} + (SUM_W + 1)'(prod_q);
  assign total_add = {1'b0, lag_rd_q} + (TOTAL_W + 1)'(item_q.chain_count);
  assign sat_flag  = sum_rd_q.mark | (lag_rd_q == TOTAL_MAX);

  // divider for finalize
  div_req_t div_req;
  div_rsp_t div_rsp;

  wmta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    done_d    = 1'b0;
    item_d    = item_q;
    idx_d     = idx_q;
    prod_d    = prod_q;
    result_d  = result_q;

    rd_en     = 1'b0;
    sum_raddr = AW'(idx_wide);
    lag_raddr = LW'(item_q.lag_num);

    sum_we    = 1'b0;
    sum_waddr = idx_q;
    sum_wdata = '0;
    lag_we    = 1'b0;
    lag_waddr = LW'(item_q.lag_num);
    lag_wdata = '0;

    div_req.start    = 1'b0;
    div_req.dividend = sum_rd_q.sum;
    div_req.divisor  = lag_rd_q;

    case (state_q)
      ST_CLEAR: begin
        // zero one table entry a cycle, lag totals along the first entries
        sum_we    = 1'b1;
        sum_waddr = clr_cnt_q;
        if (32'(clr_cnt_q) < MAX_LAGS) begin
          lag_we    = 1'b1;
          lag_waddr = LW'(clr_cnt_q);
        end
        if (clr_cnt_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          item_d  = item_i;
          state_d = ST_INDEX;
        end
      end

      ST_INDEX: begin
        idx_d  = AW'(idx_wide);
        prod_d = PROD_W'(value_clamped) * PROD_W'(item_q.chain_count);
        case (item_q.opcode)
          OP_CLEAR: begin
            clr_cnt_d = '0;
            state_d   = ST_CLEAR;
          end
          OP_ACCUM, OP_FINAL: begin
            if (in_range) begin
              rd_en   = 1'b1;
              state_d = ST_MODIFY;
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_MODIFY: begin
        if (item_q.opcode == OP_ACCUM) begin
          sum_we = 1'b1;
          if (sum_add[SUM_W]) begin
            sum_wdata.mark = 1'b1;
            sum_wdata.sum  = SUM_MAX;
          end else begin
            sum_wdata.mark = sum_rd_q.mark;
            sum_wdata.sum  = sum_add[SUM_W-1:0];
          end
          if (item_q.add_count) begin
            lag_we    = 1'b1;
            lag_wdata = total_add[TOTAL_W] ? TOTAL_MAX : total_add[TOTAL_W-1:0];
          end
          state_d = ST_IDLE;
        end else if (lag_rd_q == '0) begin
          // empty lag: entry left as is
          done_d              = 1'b1;
          result_d.mean_value = '0;
          result_d.empty_lag  = 1'b1;
          result_d.saturated  = sat_flag;
          state_d             = ST_IDLE;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIVIDE;
        end
      end

      ST_DIVIDE: begin
        if (div_rsp.done) begin
          // write back the clamped mean, mark kept
          sum_we              = 1'b1;
          sum_wdata.mark      = sum_rd_q.mark;
          sum_wdata.sum       = SUM_W'(div_rsp.quotient);
          done_d              = 1'b1;
          result_d.mean_value = div_rsp.quotient;
          result_d.empty_lag  = 1'b0;
          result_d.saturated  = sat_flag;
          state_d             = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    idx_q    <= idx_d;
    prod_q   <= prod_d;
    result_q <= result_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `WMTA_ASSERT(a_done_from_finalize, done_o |-> ($past(state_q) == ST_MODIFY || $past(state_q) == ST_DIVIDE), "result strobe without a finalize")
  `WMTA_ASSERT(a_mean_in_range, done_o |-> (result_o.mean_value <= ONE_Q15), "mean above one")
  `WMTA_ASSERT_NEVER(a_no_write_idle, (state_q == ST_IDLE) && (sum_we || lag_we), "memory write while idle")

endmodule

[rtl/core/wmta_div.sv]
// ----------------------------------------------------------------------------
// wmta_div
// restoring divider, one quotient bit a cycle, quotient clamped to 1.0
// ----------------------------------------------------------------------------
module wmta_div
  import wmta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   dvs_q, dvs_d;
  logic [QUOT_W-1:0]  quo_q, quo_d;
  logic               over;

  // quotient at or above 2^17 is clamped at once
  assign over = {1'b0, req_i.dividend} >= {req_i.divisor, {QUOT_W{1'b0}}};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      if (over) begin
        quo_d  = QUOT_W'(ONE_Q15);
        done_d = 1'b1;
        run_d  = 1'b0;
      end else begin
        rem_d = req_i.dividend;
        dvs_d = {req_i.divisor, {(QUOT_W-1){1'b0}}};
        quo_d = '0;
        cnt_d = CNT_W'(QUOT_W - 1);
        run_d = 1'b1;
      end
    end else if (run_q) begin
      if (rem_q >= dvs_q) begin
        rem_d = rem_q - dvs_q;
        quo_d = {quo_q[QUOT_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QUOT_W-2:0], 1'b0};
      end
      dvs_d = dvs_q >> 1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (quo_q > QUOT_W'(ONE_Q15)) ? ONE_Q15 : quo_q[VALUE_W-1:0];

endmodule
